/* design/interval_table_reclassifier_top_macros.svh */
// Assertion macros shared by the interval table reclassifier RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef INTERVAL_TABLE_RECLASSIFIER_TOP_MACROS_SVH
`define INTERVAL_TABLE_RECLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itr assertion failed");

// Next-cycle implication, checked outside reset.
`define ITR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itr assertion failed");

`endif

/* design/itr_pkg.sv */
// Package for the interval table reclassifier: payload structs, configuration
// type, table row type and register index constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itr_pkg;

  // Action codes carried by an input transaction.
  localparam logic ACT_CLASSIFY = 1'b0;
  localparam logic ACT_LOAD     = 1'b1;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_CLOSED    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INCLUDE_EXTREME = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NA_REPLACE      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_NA_ONLY         = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_NA_VALUE        = 3'd5;

  localparam int VAL_W      = 32;
  localparam int ROW_CNT_W  = 5;
  localparam int ROW_IDX_W  = 4;

  typedef struct packed {
    logic                    action;
    logic [ROW_IDX_W-1:0]    row_index;
    logic signed [VAL_W-1:0] lower_bound;
    logic signed [VAL_W-1:0] upper_bound;
    logic signed [VAL_W-1:0] replacement;
    logic signed [VAL_W-1:0] sample;
    logic                    sample_invalid;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic                    result_invalid;
    logic                    matched;
  } out_item_t;

  typedef struct packed {
    logic [ROW_CNT_W-1:0]    row_count;
    logic                    right_closed;
    logic                    include_extreme;
    logic                    na_replace;
    logic                    na_only;
    logic signed [VAL_W-1:0] na_value;
  } cfg_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic signed [VAL_W-1:0] repl;
  } row_t;

endpackage

`default_nettype wire

/* design/interval_table_reclassifier_top.sv */
// Interval table reclassifier: ports, configuration registers, row table,
// input and result registers. Depends on itr_pkg, itr_lookup and the macro header.
//
// Usage:
//   The input channel (in_valid/in_ready/in_data) carries two kinds of
//   transaction. A load transaction (action = load) writes one table row
//   with its lower bound, upper bound and replacement value; it produces no
//   result. A classify transaction carries a Q16.16 sample and an invalid
//   flag and produces exactly one result on out_valid/out_ready/out_data.
//   The input register and the result register lie between input acceptance
//   and out_valid. Throughput is one transaction per cycle while out_ready
//   stays high; the figure is set by the combinational parallel compare of
//   the sample against every row between the two registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register holds one more; in_ready then drops until
//   out_ready returns.
//   The cfg_ port writes configuration registers with no wait; write it only
//   while no classify transaction is in flight.
//   Reset (rst_n low, synchronous) empties both stages and restores the
//   configuration defaults. Table rows are not cleared and must be loaded
//   before row_count covers them.
`timescale 1ns / 1ps
`default_nettype none
`include "interval_table_reclassifier_top_macros.svh"

module interval_table_reclassifier_top #(
  parameter int TABLE_ROWS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  itr_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output itr_pkg::out_item_t                    out_data,
  input  logic                                  cfg_we,
  input  logic [itr_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [itr_pkg::VAL_W-1:0]             cfg_wdata
);

  itr_pkg::cfg_t      cfg_r;
  itr_pkg::row_t      rows_r [TABLE_ROWS];
  logic               s1_valid_r;
  itr_pkg::in_item_t  s1_data_r;
  logic               out_valid_r;
  itr_pkg::out_item_t out_data_r;
  itr_pkg::out_item_t lookup_res;
  logic               in_fire;
  logic               s1_is_load;
  logic               s1_go;

  // Handshake: the input stage advances when it holds a load or the result
  // register is free or being emptied.
  assign s1_is_load = (s1_data_r.action == itr_pkg::ACT_LOAD);
  assign s1_go      = s1_valid_r && (s1_is_load || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_go;
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count       <= '0;
      cfg_r.right_closed    <= 1'b1;
      cfg_r.include_extreme <= 1'b0;
      cfg_r.na_replace      <= 1'b0;
      cfg_r.na_only         <= 1'b0;
      cfg_r.na_value        <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        itr_pkg::CFG_ROW_COUNT:       cfg_r.row_count <= cfg_wdata[itr_pkg::ROW_CNT_W-1:0];
        itr_pkg::CFG_RIGHT_CLOSED:    cfg_r.right_closed <= cfg_wdata[0];
        itr_pkg::CFG_INCLUDE_EXTREME: cfg_r.include_extreme <= cfg_wdata[0];
        itr_pkg::CFG_NA_REPLACE:      cfg_r.na_replace <= cfg_wdata[0];
        itr_pkg::CFG_NA_ONLY:         cfg_r.na_only <= cfg_wdata[0];
        itr_pkg::CFG_NA_VALUE:        cfg_r.na_value <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // Table rows: a load transaction writes its row as it is accepted, so any
  // later classify transaction sees it. Indexes past the table are dropped.
  for (genvar j = 0; j < TABLE_ROWS; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (in_fire && (in_data.action == itr_pkg::ACT_LOAD) &&
          ({{(32 - itr_pkg::ROW_IDX_W){1'b0}}, in_data.row_index} == 32'(j))) begin
        rows_r[j].low  <= in_data.lower_bound;
        rows_r[j].high <= in_data.upper_bound;
        rows_r[j].repl <= in_data.replacement;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // Parallel row compare and selection.
  itr_lookup #(
    .TABLE_ROWS(TABLE_ROWS)
  ) u_lookup (
    .cfg           (cfg_r),
    .rows          (rows_r),
    .sample        (s1_data_r.sample),
    .sample_invalid(s1_data_r.sample_invalid),
    .result        (lookup_res)
  );

  // Result register: filled by a classify transaction leaving the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && !s1_is_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_is_load) begin
      out_data_r <= lookup_res;
    end
  end

  // Checks on the stage control and result fields.
  `ITR_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_fire, s1_valid_r)
  `ITR_ASSERT_NEXT(a_classify_gives_result, clk, rst_n, s1_go && !s1_is_load, out_valid_r)
  `ITR_ASSERT_NEXT(a_load_gives_no_result, clk, rst_n, s1_valid_r && s1_is_load && (!out_valid_r || out_ready), !out_valid_r)
  `ITR_ASSERT_NOW(a_matched_is_valid, clk, rst_n, out_valid_r && out_data_r.matched, !out_data_r.result_invalid)

endmodule

`default_nettype wire

/* design/itr_lookup.sv */
// Combinational classification of one sample against all table rows in parallel.
// Depends on itr_pkg for the configuration, row and result types.
`timescale 1ns / 1ps
`default_nettype none

module itr_lookup #(
  parameter int TABLE_ROWS = 16
) (
  input  itr_pkg::cfg_t                   cfg,
  input  itr_pkg::row_t                   rows [TABLE_ROWS],
  input  logic signed [itr_pkg::VAL_W-1:0] sample,
  input  logic                            sample_invalid,
  output itr_pkg::out_item_t              result
);

  logic [TABLE_ROWS-1:0] in_use;
  logic [TABLE_ROWS-1:0] hit;
  logic [TABLE_ROWS-1:0] ext_eq;
  logic [TABLE_ROWS-1:0] ext_beats;
  logic [TABLE_ROWS-1:0] hit_first;
  logic [TABLE_ROWS-1:0] ext_first;
  logic                  ext_hit;
  logic signed [itr_pkg::VAL_W-1:0] hit_value;
  logic signed [itr_pkg::VAL_W-1:0] ext_value;

  // Per-row compares: interval membership and extreme-bound tests.
  always_comb begin
    for (int j = 0; j < TABLE_ROWS; j++) begin
      in_use[j] = ({{(32 - itr_pkg::ROW_CNT_W){1'b0}}, cfg.row_count} > 32'(j));
      if (cfg.right_closed) begin
        hit[j]       = in_use[j] && (sample > rows[j].low) && (sample <= rows[j].high);
        ext_eq[j]    = in_use[j] && (sample == rows[j].low);
        ext_beats[j] = in_use[j] && (rows[j].low < sample);
      end else begin
        hit[j]       = in_use[j] && (sample >= rows[j].low) && (sample < rows[j].high);
        ext_eq[j]    = in_use[j] && (sample == rows[j].high);
        ext_beats[j] = in_use[j] && (rows[j].high > sample);
      end
    end
  end

  // The sample is the extreme bound when some row holds it and no row goes past it.
  assign ext_hit = cfg.include_extreme && (|ext_eq) && !(|ext_beats);

  // First-row selection: one-hot of the lowest matching index, then an AND-OR mux.
  always_comb begin
    logic hit_seen;
    logic ext_seen;
    hit_seen  = 1'b0;
    ext_seen  = 1'b0;
    hit_value = '0;
    ext_value = '0;
    for (int j = 0; j < TABLE_ROWS; j++) begin
      hit_first[j] = hit[j] && !hit_seen;
      ext_first[j] = ext_eq[j] && !ext_seen;
      hit_seen     = hit_seen || hit[j];
      ext_seen     = ext_seen || ext_eq[j];
    end
    for (int j = 0; j < TABLE_ROWS; j++) begin
      hit_value = hit_value | ({itr_pkg::VAL_W{hit_first[j]}} & rows[j].repl);
      ext_value = ext_value | ({itr_pkg::VAL_W{ext_first[j]}} & rows[j].repl);
    end
  end

  // Final choice in priority order: invalid handling, bypass, extreme bound, table.
  always_comb begin
    result.result_value   = sample;
    result.result_invalid = 1'b0;
    result.matched        = 1'b0;
    if (sample_invalid) begin
      if (cfg.na_only || cfg.na_replace) begin
        result.result_value = cfg.na_value;
        result.matched      = 1'b1;
      end else begin
        result.result_invalid = 1'b1;
      end
    end else if (cfg.na_only) begin
      result.matched = 1'b0;
    end else if (ext_hit) begin
      result.result_value = ext_value;
      result.matched      = 1'b1;
    end else if (|hit) begin
      result.result_value = hit_value;
      result.matched      = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* bench/tb_interval_table_reclassifier_top.sv */
// Self-checking testbench for interval_table_reclassifier_top: directed script, then random
// phases, with every result checked against a predictor of the table lookup or a scripted expectation.
// Depends on itr_pkg and the interval_table_reclassifier_top RTL.
`timescale 1ns / 1ps

module tb_interval_table_reclassifier_top;

  localparam int TABLE_ROWS      = 16;
  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int TIMEOUT_NS      = 2_000_000;

  // One line of the directed script: a register write or an input transaction.
  typedef struct {
    bit                             is_cfg;
    logic [itr_pkg::CFG_ADDR_W-1:0] reg_idx;
    logic [itr_pkg::VAL_W-1:0]      reg_val;
    itr_pkg::in_item_t              item;
    bit                             has_want;
    itr_pkg::out_item_t             want;
  } script_line_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  itr_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  itr_pkg::out_item_t             out_data;
  logic                           cfg_we;
  logic [itr_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [itr_pkg::VAL_W-1:0]      cfg_wdata;

  // Predictor state: the table and configuration as the block should hold them.
  itr_pkg::row_t      shadow_rows [TABLE_ROWS];
  itr_pkg::cfg_t      shadow_cfg;
  itr_pkg::out_item_t pending_results [$];
  int                 mismatch_count = 0;
  bit                 stream_live = 1'b0;
  bit                 send_steady = 1'b0;
  bit                 recv_steady = 1'b0;

  interval_table_reclassifier_top #(
    .TABLE_ROWS(TABLE_ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic itr_pkg::out_item_t make_result(input logic [itr_pkg::VAL_W-1:0] value,
                                                     input logic inv, input logic hit);
    itr_pkg::out_item_t res;
    res.result_value   = value;
    res.result_invalid = inv;
    res.matched        = hit;
    return res;
  endfunction

  // Applies one input transaction to the shadow table and returns 1 when it yields a result.
  function automatic bit reclassify(input itr_pkg::in_item_t it,
                                    output itr_pkg::out_item_t res);
    logic signed [itr_pkg::VAL_W-1:0] smp;
    logic signed [itr_pkg::VAL_W-1:0] bound;
    int                               rows;
    int                               best;
    bit                               hit;
    res = '0;
    if (it.action == itr_pkg::ACT_LOAD) begin
      if (it.row_index < TABLE_ROWS) begin
        shadow_rows[it.row_index].low  = it.lower_bound;
        shadow_rows[it.row_index].high = it.upper_bound;
        shadow_rows[it.row_index].repl = it.replacement;
      end
      return 1'b0;
    end
    // Invalid samples never reach the table.
    if (it.sample_invalid) begin
      if (shadow_cfg.na_only || shadow_cfg.na_replace) begin
        res = make_result(shadow_cfg.na_value, 1'b0, 1'b1);
      end else begin
        res = make_result(it.sample, 1'b1, 1'b0);
      end
      return 1'b1;
    end
    res = make_result(it.sample, 1'b0, 1'b0);
    if (shadow_cfg.na_only) return 1'b1;
    rows = (shadow_cfg.row_count < TABLE_ROWS) ? int'(shadow_cfg.row_count) : TABLE_ROWS;
    smp  = it.sample;
    // The extreme bound of the table is checked ahead of the interval search.
    if (shadow_cfg.include_extreme && rows > 0) begin
      best = 0;
      for (int j = 1; j < rows; j++) begin
        if (shadow_cfg.right_closed ? (shadow_rows[j].low < shadow_rows[best].low)
                                    : (shadow_rows[j].high > shadow_rows[best].high)) begin
          best = j;
        end
      end
      bound = shadow_cfg.right_closed ? shadow_rows[best].low : shadow_rows[best].high;
      if (smp == bound) begin
        res = make_result(shadow_rows[best].repl, 1'b0, 1'b1);
        return 1'b1;
      end
    end
    // First row in index order whose interval holds the sample wins.
    for (int j = 0; j < rows; j++) begin
      hit = shadow_cfg.right_closed ?
            (smp > shadow_rows[j].low && smp <= shadow_rows[j].high) :
            (smp >= shadow_rows[j].low && smp < shadow_rows[j].high);
      if (hit) begin
        res = make_result(shadow_rows[j].repl, 1'b0, 1'b1);
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic script_line_t mk_cfg(input logic [itr_pkg::CFG_ADDR_W-1:0] idx,
                                          input logic [itr_pkg::VAL_W-1:0] val);
    script_line_t s;
    s = '{default: '0};
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic script_line_t mk_load(input logic [itr_pkg::ROW_IDX_W-1:0] idx,
                                           input logic [itr_pkg::VAL_W-1:0] lo,
                                           input logic [itr_pkg::VAL_W-1:0] hi,
                                           input logic [itr_pkg::VAL_W-1:0] nv);
    script_line_t s;
    s = '{default: '0};
    s.item.action      = itr_pkg::ACT_LOAD;
    s.item.row_index   = idx;
    s.item.lower_bound = lo;
    s.item.upper_bound = hi;
    s.item.replacement = nv;
    return s;
  endfunction

  function automatic script_line_t mk_cls(input logic [itr_pkg::VAL_W-1:0] smp,
                                          input logic inv);
    script_line_t s;
    s = '{default: '0};
    s.item.action         = itr_pkg::ACT_CLASSIFY;
    s.item.sample         = smp;
    s.item.sample_invalid = inv;
    return s;
  endfunction

  function automatic script_line_t mk_cls_want(input logic [itr_pkg::VAL_W-1:0] smp,
                                               input logic inv,
                                               input logic [itr_pkg::VAL_W-1:0] value,
                                               input logic rinv, input logic hit);
    script_line_t s;
    s          = mk_cls(smp, inv);
    s.has_want = 1'b1;
    s.want     = make_result(value, rinv, hit);
    return s;
  endfunction

  // Small signed values near zero, so that random intervals overlap and get hit.
  function automatic logic [itr_pkg::VAL_W-1:0] near_zero();
    return int'($urandom_range(0, 32'hA0000)) - 32'sh50000;
  endfunction

  function automatic itr_pkg::in_item_t random_load();
    itr_pkg::in_item_t it;
    logic [31:0]       pick;
    it                = '0;
    it.action         = itr_pkg::ACT_LOAD;
    pick              = $urandom_range(0, TABLE_ROWS - 1);
    it.row_index      = pick[itr_pkg::ROW_IDX_W-1:0];
    it.replacement    = $urandom;
    it.sample         = $urandom;
    it.sample_invalid = ($urandom_range(0, 1) == 1);
    case ($urandom_range(0, 9))
      7: begin
        it.lower_bound = $urandom;
        it.upper_bound = $urandom;
      end
      8: begin
        it.lower_bound = 32'h8000_0000;
        it.upper_bound = near_zero();
      end
      9: begin
        it.lower_bound = near_zero();
        it.upper_bound = 32'h7FFF_FFFF;
      end
      default: begin
        // Mostly short intervals; some come out empty with high below low.
        it.lower_bound = near_zero();
        it.upper_bound = it.lower_bound + int'($urandom_range(0, 32'h60000)) - 32'sh8000;
      end
    endcase
    return it;
  endfunction

  function automatic itr_pkg::in_item_t random_item();
    itr_pkg::in_item_t it;
    int                j;
    logic [31:0]       pick;
    if ($urandom_range(0, 99) < 15) return random_load();
    it                = '0;
    it.action         = itr_pkg::ACT_CLASSIFY;
    pick              = $urandom_range(0, TABLE_ROWS - 1);
    it.row_index      = pick[itr_pkg::ROW_IDX_W-1:0];
    it.lower_bound    = $urandom;
    it.upper_bound    = $urandom;
    it.replacement    = $urandom;
    it.sample_invalid = ($urandom_range(0, 7) == 0);
    j                 = $urandom_range(0, TABLE_ROWS - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // On or next to a bound of some row.
        it.sample = ($urandom_range(0, 1) ? shadow_rows[j].low : shadow_rows[j].high) +
                    (int'($urandom_range(0, 2)) - 1);
      end
      4, 5, 6: it.sample = near_zero();
      7:       it.sample = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       it.sample = 32'h8000_0000;
          1:       it.sample = 32'h7FFF_FFFF;
          2:       it.sample = 32'h0000_0000;
          default: it.sample = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return it;
  endfunction

  // Writes one register once every classify transaction in flight has drained.
  task automatic write_reg(input logic [itr_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [itr_pkg::VAL_W-1:0] val);
    if (stream_live) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      stream_live = 1'b0;
    end
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      itr_pkg::CFG_ROW_COUNT:       shadow_cfg.row_count       = val[itr_pkg::ROW_CNT_W-1:0];
      itr_pkg::CFG_RIGHT_CLOSED:    shadow_cfg.right_closed    = val[0];
      itr_pkg::CFG_INCLUDE_EXTREME: shadow_cfg.include_extreme = val[0];
      itr_pkg::CFG_NA_REPLACE:      shadow_cfg.na_replace      = val[0];
      itr_pkg::CFG_NA_ONLY:         shadow_cfg.na_only         = val[0];
      itr_pkg::CFG_NA_VALUE:        shadow_cfg.na_value        = val;
      default: ;
    endcase
  endtask

  // Offers one transaction after a random gap and records its expected result on acceptance.
  task automatic send_item(input itr_pkg::in_item_t it, input bit has_want,
                           input itr_pkg::out_item_t want);
    int                 gap;
    itr_pkg::out_item_t res;
    if (cfg_we) cfg_we <= 1'b0;
    if ($urandom_range(0, 23) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (reclassify(it, res)) pending_results.push_back(has_want ? want : res);
    stream_live = 1'b1;
  endtask

  // Stimulus: directed script, a full table load, then random phases.
  initial begin
    script_line_t      directed [$];
    itr_pkg::in_item_t it;
    int                count_sel;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    shadow_cfg = '0;
    shadow_cfg.right_closed = 1'b1;
    foreach (shadow_rows[r]) shadow_rows[r] = '0;

    // No rows in use, then an invalid sample with substitution off.
    directed.push_back(mk_cls_want(32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0));
    directed.push_back(mk_cls_want(32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1, 1'b0));
    // Two overlapping rows and a catch-all spanning the full range.
    directed.push_back(mk_load(4'd0, 32'h0001_0000, 32'h0005_0000, 32'h0064_0000));
    directed.push_back(mk_load(4'd1, 32'h0003_0000, 32'h0008_0000, 32'h00C8_0000));
    directed.push_back(mk_load(4'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk_cfg(itr_pkg::CFG_ROW_COUNT, 32'd3));
    directed.push_back(mk_cls(32'h0001_0000, 1'b0));
    directed.push_back(mk_cls(32'h0005_0000, 1'b0));
    directed.push_back(mk_cls(32'h0006_0000, 1'b0));
    directed.push_back(mk_cls(32'h8000_0000, 1'b0));
    directed.push_back(mk_cls(32'h7FFF_FFFF, 1'b0));
    // Least lower bound becomes a hit with the extreme rule.
    directed.push_back(mk_cfg(itr_pkg::CFG_INCLUDE_EXTREME, 32'd1));
    directed.push_back(mk_cls(32'h8000_0000, 1'b0));
    directed.push_back(mk_cls_want(32'h0001_0000, 1'b1, 32'h0001_0000, 1'b1, 1'b0));
    // Left-closed intervals, greatest upper bound as the extreme.
    directed.push_back(mk_cfg(itr_pkg::CFG_RIGHT_CLOSED, 32'd0));
    directed.push_back(mk_cls(32'h7FFF_FFFF, 1'b0));
    directed.push_back(mk_cls(32'h0001_0000, 1'b0));
    directed.push_back(mk_cls(32'h0005_0000, 1'b0));
    directed.push_back(mk_cfg(itr_pkg::CFG_INCLUDE_EXTREME, 32'd0));
    directed.push_back(mk_cls(32'h7FFF_FFFF, 1'b0));
    directed.push_back(mk_cls(32'h8000_0000, 1'b0));
    // Substitution of invalid samples in both closure modes.
    directed.push_back(mk_cfg(itr_pkg::CFG_NA_VALUE, 32'h8000_0000));
    directed.push_back(mk_cfg(itr_pkg::CFG_NA_REPLACE, 32'd1));
    directed.push_back(mk_cls_want(32'h1234_5678, 1'b1, 32'h8000_0000, 1'b0, 1'b1));
    directed.push_back(mk_cfg(itr_pkg::CFG_RIGHT_CLOSED, 32'd1));
    directed.push_back(mk_cls_want(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b1));
    // Bypass mode: valid samples pass, invalid ones are substituted.
    directed.push_back(mk_cfg(itr_pkg::CFG_NA_REPLACE, 32'd0));
    directed.push_back(mk_cfg(itr_pkg::CFG_NA_ONLY, 32'd1));
    directed.push_back(mk_cfg(itr_pkg::CFG_NA_VALUE, 32'h7FFF_FFFF));
    directed.push_back(mk_cls_want(32'h0005_0000, 1'b0, 32'h0005_0000, 1'b0, 1'b0));
    directed.push_back(mk_cls_want(32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_item(directed[i].item, directed[i].has_want, directed[i].want);
      end
    end

    // Every row gets written before row counts above three come into use.
    for (int r = 0; r < TABLE_ROWS; r++) begin
      it           = random_load();
      it.row_index = r[itr_pkg::ROW_IDX_W-1:0];
      send_item(it, 1'b0, '0);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 7)
        0:       count_sel = 0;
        1:       count_sel = 1;
        2:       count_sel = TABLE_ROWS;
        3:       count_sel = 31;
        default: count_sel = $urandom_range(0, 31);
      endcase
      write_reg(itr_pkg::CFG_ROW_COUNT, count_sel);
      write_reg(itr_pkg::CFG_RIGHT_CLOSED, p % 2);
      write_reg(itr_pkg::CFG_INCLUDE_EXTREME, (p / 2) % 2);
      write_reg(itr_pkg::CFG_NA_REPLACE, $urandom_range(0, 1));
      write_reg(itr_pkg::CFG_NA_ONLY, ((p % 5) == 4) ? 32'd1 : 32'd0);
      write_reg(itr_pkg::CFG_NA_VALUE,
                (p == 0) ? 32'h8000_0000 : (p == 1) ? 32'h7FFF_FFFF : $urandom);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_item(random_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stalls, each accepted transaction checked against the oldest expectation.
  initial begin
    itr_pkg::out_item_t want;
    int                 stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) recv_steady = !recv_steady;
      stall = recv_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result at %0t: value %h invalid %b matched %b", $realtime,
                   out_data.result_value, out_data.result_invalid, out_data.matched);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value ||
            out_data.result_invalid !== want.result_invalid ||
            out_data.matched !== want.matched) begin
          if (mismatch_count < 10) begin
            $display("result mismatch at %0t: expected value %h invalid %b matched %b, got %h %b %b",
                     $realtime, want.result_value, want.result_invalid, want.matched,
                     out_data.result_value, out_data.result_invalid, out_data.matched);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
